// ----- design/cdoc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdoc_pkg: shared types and constants of the calendar date converter
// Holds operation codes, sequencer states, unit control and the month table.
// ----------------------------------------------------------------------------
package cdoc_pkg;

	localparam logic OP_TO_ORDINAL = 1'b0;
	localparam logic OP_TO_DATE    = 1'b1;

	localparam int OUT_TDATA_W = 24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESIDUE,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} unit_ctl_t;

	// Length of month m in a common (leap = 0) or leap (leap = 1) year.
	function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
		logic [4:0] d;
		begin
			case (m) inside
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
				4'd2: d = leap ? 5'd29 : 5'd28;
				default: d = 5'd0;
			endcase
			return d;
		end
	endfunction

endpackage

// ----- design/cdoc_mod25.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdoc_mod25: divisibility of the year by 25
// Multiplies the year by the inverse of 25 modulo 2^YEAR_BITS and compares the
// product with a bound; a step after the load registers the product and raises done.
// ----------------------------------------------------------------------------
module cdoc_mod25
	import cdoc_pkg::*;
#(
	parameter int YEAR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  unit_ctl_t            ctl,
	input  logic [YEAR_BITS-1:0] year,
	output logic                 done,
	output logic                 div25
);

	// Multiplying by the inverse of 25 modulo 2^YEAR_BITS is a one-to-one map that
	// sends the multiples of 25 onto 0 .. (2^YEAR_BITS - 1) / 25 and every other
	// year above that bound.
	localparam logic [31:0]          INV25_W32 = 32'hC28F5C29;
	localparam logic [YEAR_BITS-1:0] INV25     = INV25_W32[YEAR_BITS-1:0];
	localparam logic [YEAR_BITS-1:0] MULT_MAX  =
		YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / 64'd25);

	logic [YEAR_BITS-1:0] year_q;
	logic [YEAR_BITS-1:0] prod;
	logic [YEAR_BITS-1:0] prod_q;
	logic                 done_q;

	assign prod  = year_q * INV25;
	assign done  = done_q;
	assign div25 = (prod_q <= MULT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (ctl.load) begin
			done_q <= 1'b0;
		end else if (ctl.step) begin
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			year_q <= year;
		end else if (ctl.step && !done_q) begin
			prod_q <= prod;
		end
	end

endmodule

// ----- design/cdoc_walk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdoc_walk: month walker with one shared add/subtract unit
// Adds month lengths up to a date, or subtracts them down from a day of year.
// ----------------------------------------------------------------------------
module cdoc_walk
	import cdoc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  unit_ctl_t  ctl,
	input  logic       op,
	input  logic [3:0] month_tgt,
	input  logic [8:0] init,
	input  logic       leap,
	output logic [8:0] acc,
	output logic [3:0] month,
	output logic       done
);

	logic       op_q;
	logic [3:0] tgt_q;
	logic [8:0] acc_q;
	logic [3:0] mon_q;
	logic [8:0] len;

	assign len = {4'd0, month_days(leap, mon_q)};

	always_comb begin
		if (op_q == OP_TO_ORDINAL) begin
			done = (mon_q >= tgt_q);
		end else begin
			done = (mon_q == 4'd12) || (acc_q <= len);
		end
	end

	assign acc   = acc_q;
	assign month = mon_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_TO_ORDINAL;
		end else if (ctl.load) begin
			op_q <= op;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			tgt_q <= month_tgt;
			acc_q <= init;
			mon_q <= 4'd1;
		end else if (ctl.step && !done) begin
			acc_q <= (op_q == OP_TO_ORDINAL) ? acc_q + len : acc_q - len;
			mon_q <= mon_q + 4'd1;
		end
	end

endmodule

// ----- design/calendar_date_ordinal_convert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_ordinal_convert: Gregorian date to day-of-year and back
// Sequencer around a mod-25 divisibility unit and a month-walking adder.
// ----------------------------------------------------------------------------
// One transaction runs from acceptance through the residue and, if valid, the
// month walk to the result register; a new one is accepted only after the last
// one has been written there, which may wait for the output register to empty. The
// leap-year test needs divisibility by 25, which one multiply by the inverse of
// 25 settles, and the conversion then steps through up to eleven month lengths
// on a single adder, one month per cycle. The input is ready only
// while the sequencer is idle; a finished result sits in the output register
// until it is taken, and the next transaction may be accepted meanwhile. An
// invalid date gives a result with valid_res low and every other field zero.
// ----------------------------------------------------------------------------
module calendar_date_ordinal_convert
	import cdoc_pkg::*;
#(
	parameter  int YEAR_BITS  = 16,
	localparam int IN_TDATA_W = ((YEAR_BITS + 18 + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// year_in, month_in[3:0], day_in[4:0], ordinal_in[8:0], zero padding
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// operation
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// leap_year, ordinal_out[8:0], month_out[3:0], day_out[4:0], zero padding
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// valid_res
	output logic                   m_tuser
);

	state_t state_q, state_d;

	unit_ctl_t res_ctl, walk_ctl;
	logic      res_done, div25;
	logic      walk_done;
	logic [8:0] walk_acc;
	logic [3:0] walk_month;

	logic       op_q;
	logic [3:0] month_q;
	logic [4:0] day_q;
	logic [8:0] ord_q;
	logic       yzero_q;
	logic [3:0] ylow_q;
	logic       leap_q;
	logic       ok_q;

	logic       leap_now;
	logic       ok_now;
	logic       accept;
	logic       out_free;

	logic       m_tvalid_q;
	logic       valid_q;
	logic       leap_out_q;
	logic [8:0] ord_out_q;
	logic [3:0] mon_out_q;
	logic [4:0] day_out_q;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Leap when divisible by 4 and either not by 25 (hence not by 100) or by 16
	// (together with 25 this is divisibility by 400).
	assign leap_now = (ylow_q[1:0] == 2'd0) && (!div25 || (ylow_q == 4'd0));

	always_comb begin
		ok_now = 1'b0;
		if (!yzero_q) begin
			if (op_q == OP_TO_ORDINAL) begin
				ok_now = (month_q >= 4'd1) && (month_q <= 4'd12) && (day_q != 5'd0)
					&& (day_q <= month_days(leap_now, month_q));
			end else begin
				ok_now = (ord_q != 9'd0) && (ord_q <= (9'd365 + {8'd0, leap_now}));
			end
		end
	end

	cdoc_mod25 #(
		.YEAR_BITS(YEAR_BITS)
	) u_mod25 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (res_ctl),
		.year   (s_tdata[YEAR_BITS-1:0]),
		.done   (res_done),
		.div25  (div25)
	);

	cdoc_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (walk_ctl),
		.op        (op_q),
		.month_tgt (month_q),
		.init      ((op_q == OP_TO_ORDINAL) ? {4'd0, day_q} : ord_q),
		.leap      (leap_q),
		.acc       (walk_acc),
		.month     (walk_month),
		.done      (walk_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		res_ctl.load  = 1'b0;
		res_ctl.step  = 1'b0;
		walk_ctl.load = 1'b0;
		walk_ctl.step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready     = 1'b1;
				res_ctl.load = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_RESIDUE;
				end
			end
			ST_RESIDUE: begin
				res_ctl.step = 1'b1;
				if (res_done) begin
					walk_ctl.load = 1'b1;
					state_d       = ok_now ? ST_WALK : ST_DONE;
				end
			end
			ST_WALK: begin
				walk_ctl.step = 1'b1;
				if (walk_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tuser;
			month_q <= s_tdata[YEAR_BITS +: 4];
			day_q   <= s_tdata[YEAR_BITS + 4 +: 5];
			ord_q   <= s_tdata[YEAR_BITS + 9 +: 9];
			yzero_q <= (s_tdata[YEAR_BITS-1:0] == '0);
			ylow_q  <= s_tdata[3:0];
		end
		if (state_q == ST_RESIDUE && res_done) begin
			leap_q <= leap_now;
			ok_q   <= ok_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			valid_q    <= ok_q;
			leap_out_q <= ok_q && leap_q;
			ord_out_q  <= (ok_q && op_q == OP_TO_ORDINAL) ? walk_acc : 9'd0;
			mon_out_q  <= (ok_q && op_q == OP_TO_DATE) ? walk_month : 4'd0;
			day_out_q  <= (ok_q && op_q == OP_TO_DATE) ? walk_acc[4:0] : 5'd0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = valid_q;
	assign m_tdata  = {5'd0, day_out_q, mon_out_q, ord_out_q, leap_out_q};

endmodule

// ----- tb/calendar_date_ordinal_convert_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_ordinal_convert_tb: self-checking bench for the date converter
// Sends directed and random conversions in both directions over the stream
// input. The sender works in bursts and the receiver stalls on its own pattern.
// A scoreboard predicts each result and compares it field by field with what
// the block returns.
// ----------------------------------------------------------------------------
module calendar_date_ordinal_convert_tb
	import cdoc_pkg::*;
();

	localparam int YEAR_BITS     = 16;
	localparam int IN_TDATA_W    = ((YEAR_BITS + 18 + 7) / 8) * 8;
	localparam int RANDOM_ITEMS  = 850;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic       valid;
		logic       leap;
		logic [8:0] ordinal;
		logic [3:0] month;
		logic [4:0] day;
	} conv_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	calendar_date_ordinal_convert #(
		.YEAR_BITS(YEAR_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	function automatic logic is_leap_year(input logic [YEAR_BITS-1:0] year);
		int y;
		y = int'(year);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_length(input logic leap, input int m);
		case (m)
			2: return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			1, 3, 5, 7, 8, 10, 12: return 31;
			default: return 0;
		endcase
	endfunction

	function automatic conv_result_t convert_date(input logic op,
			input logic [YEAR_BITS-1:0] year, input logic [3:0] month,
			input logic [4:0] day, input logic [8:0] ordinal);
		conv_result_t r;
		logic leap;
		int acc;
		int m;
		r = '0;
		leap = is_leap_year(year);
		if (year != 0) begin
			if (op == OP_TO_ORDINAL) begin
				if (month >= 1 && month <= 12 && day >= 1 &&
						day <= month_length(leap, month)) begin
					acc = int'(day);
					for (m = 1; m < month; m++)
						acc += month_length(leap, m);
					r.valid   = 1'b1;
					r.leap    = leap;
					r.ordinal = 9'(acc);
				end
			end else begin
				if (ordinal >= 1 && ordinal <= 365 + leap) begin
					acc = int'(ordinal);
					m = 1;
					while (m < 12 && acc > month_length(leap, m)) begin
						acc -= month_length(leap, m);
						m++;
					end
					r.valid = 1'b1;
					r.leap  = leap;
					r.month = 4'(m);
					r.day   = 5'(acc);
				end
			end
		end
		return r;
	endfunction

	class conversion_scoreboard;
		conv_result_t expected_q[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void note_request(input logic op, input logic [YEAR_BITS-1:0] year,
				input logic [3:0] month, input logic [4:0] day, input logic [8:0] ordinal);
			expected_q.push_back(convert_date(op, year, month, day, ordinal));
		endfunction

		function void compare_field(input string name, input int exp_val, input int act_val);
			if (exp_val != act_val) begin
				$error("%s: expected %0d, actual %0d", name, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_result(input logic valid_bit, input logic [OUT_TDATA_W-1:0] data);
			conv_result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("result transaction with no conversion outstanding");
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			compare_field("valid_res", exp_r.valid, valid_bit);
			compare_field("leap_year", exp_r.leap, data[0]);
			compare_field("ordinal_out", exp_r.ordinal, data[9:1]);
			compare_field("month_out", exp_r.month, data[13:10]);
			compare_field("day_out", exp_r.day, data[18:14]);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	conversion_scoreboard sb;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: checks each result taken and counts cycles in which nothing moves.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** calendar_date_ordinal_convert: FAILED **");
			$finish;
		end
	end

	// Receiver backpressure: the stall style is drawn at random from four modes,
	// one of which keeps the receiver always ready.
	initial begin
		int cycle;
		int stall_mode;
		int stall_left;
		logic ready;
		cycle = 0;
		stall_mode = 0;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			cycle++;
			if (cycle % 300 == 0)
				stall_mode = $urandom_range(0, 3);
			if (stall_left > 0) begin
				ready = 1'b0;
				stall_left--;
			end else begin
				ready = 1'b1;
				case (stall_mode)
					1: if ($urandom_range(0, 2) == 0) begin
						ready = 1'b0;
						stall_left = $urandom_range(0, 2);
					end
					2: if ($urandom_range(0, 7) == 0) begin
						ready = 1'b0;
						stall_left = $urandom_range(4, 11);
					end
					3: ready = cycle[0];
					default: ready = 1'b1;
				endcase
			end
			m_tready <= ready;
		end
	end

	task automatic send_item(input logic op, input logic [YEAR_BITS-1:0] year,
			input logic [3:0] month, input logic [4:0] day, input logic [8:0] ordinal);
		logic [IN_TDATA_W-1:0] word;
		word = '0;
		word[YEAR_BITS-1:0]              = year;
		word[YEAR_BITS+3:YEAR_BITS]      = month;
		word[YEAR_BITS+8:YEAR_BITS+4]    = day;
		word[YEAR_BITS+17:YEAR_BITS+9]   = ordinal;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, year, month, day, ordinal);
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	task automatic drain_results();
		pause_sender(1);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_item();
		logic op;
		logic [YEAR_BITS-1:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [8:0] ordinal;
		logic leap;
		int mlen;
		op      = 1'($urandom_range(0, 1));
		month   = 4'($urandom_range(0, 15));
		day     = 5'($urandom_range(0, 31));
		ordinal = 9'($urandom_range(0, 511));
		case ($urandom_range(0, 9))
			0: year = YEAR_BITS'($urandom_range(1, 3000));
			1: year = YEAR_BITS'(100 * $urandom_range(1, 655));
			2: year = YEAR_BITS'(400 * $urandom_range(1, 163));
			3: year = YEAR_BITS'(4 * $urandom_range(1, 16383));
			4: year = YEAR_BITS'($urandom_range(65500, 65535));
			default: year = YEAR_BITS'($urandom());
		endcase
		leap = is_leap_year(year);
		if ($urandom_range(0, 99) < 85) begin
			// Well-formed request; the date and the ordinal fields both get in-range values.
			if (year == 0)
				year = 1;
			leap = is_leap_year(year);
			month = 4'($urandom_range(1, 12));
			mlen = month_length(leap, month);
			day = 5'(($urandom_range(0, 4) == 0) ? mlen : $urandom_range(1, mlen));
			case ($urandom_range(0, 5))
				0: ordinal = 9'(365 + leap);
				1: ordinal = 1;
				default: ordinal = 9'($urandom_range(1, 365 + leap));
			endcase
		end else if ($urandom_range(0, 4) == 0) begin
			year = '0;
		end else if ($urandom_range(0, 1) == 0) begin
			// Just past the end of the month (day 0 after wrapping for 31-day months) or of the year.
			month = 4'($urandom_range(1, 12));
			day = 5'(month_length(leap, month) + 1);
			ordinal = 9'(366 + leap);
		end
		send_item(op, year, month, day, ordinal);
	endtask

	initial begin
		int burst_left;
		int n;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Date to day of year: century rules, month and day limits.
		send_item(OP_TO_ORDINAL, 16'd2000, 4'd1, 5'd1, 9'd0);
		send_item(OP_TO_ORDINAL, 16'd2000, 4'd12, 5'd31, 9'h1FF);
		send_item(OP_TO_ORDINAL, 16'd1900, 4'd2, 5'd29, 9'd0);
		send_item(OP_TO_ORDINAL, 16'd1900, 4'd2, 5'd28, 9'd0);
		send_item(OP_TO_ORDINAL, 16'd2024, 4'd2, 5'd29, 9'd0);
		send_item(OP_TO_ORDINAL, 16'd2023, 4'd2, 5'd29, 9'd0);
		send_item(OP_TO_ORDINAL, 16'd0, 4'd3, 5'd15, 9'd0);
		send_item(OP_TO_ORDINAL, 16'hFFFF, 4'd12, 5'd31, 9'd0);
		send_item(OP_TO_ORDINAL, 16'd1, 4'd0, 5'd1, 9'd0);
		send_item(OP_TO_ORDINAL, 16'd1, 4'd13, 5'd1, 9'd0);
		send_item(OP_TO_ORDINAL, 16'd1, 4'd15, 5'd31, 9'd0);
		send_item(OP_TO_ORDINAL, 16'd2001, 4'd5, 5'd0, 9'd0);
		send_item(OP_TO_ORDINAL, 16'd2001, 4'd4, 5'd31, 9'd0);
		send_item(OP_TO_ORDINAL, 16'd1, 4'd1, 5'd1, 9'd0);
		// Day of year to date: year ends, leap day, out-of-range ordinals.
		send_item(OP_TO_DATE, 16'd2000, 4'd0, 5'd0, 9'd1);
		send_item(OP_TO_DATE, 16'd2000, 4'd15, 5'd31, 9'd366);
		send_item(OP_TO_DATE, 16'd2023, 4'd0, 5'd0, 9'd366);
		send_item(OP_TO_DATE, 16'd2023, 4'd0, 5'd0, 9'd365);
		send_item(OP_TO_DATE, 16'd2023, 4'd0, 5'd0, 9'd0);
		send_item(OP_TO_DATE, 16'd2023, 4'd0, 5'd0, 9'h1FF);
		send_item(OP_TO_DATE, 16'd2400, 4'd0, 5'd0, 9'd60);
		send_item(OP_TO_DATE, 16'd2100, 4'd0, 5'd0, 9'd60);
		send_item(OP_TO_DATE, 16'd0, 4'd0, 5'd0, 9'd100);
		send_item(OP_TO_DATE, 16'hFFFF, 4'd0, 5'd0, 9'd365);
		drain_results();

		burst_left = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3)
				drain_results();
			if (burst_left == 0) begin
				pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
				burst_left = $urandom_range(1, 30);
			end
			burst_left--;
			send_random_item();
		end
		pause_sender(1);

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** calendar_date_ordinal_convert: PASSED **");
		else
			$display("** calendar_date_ordinal_convert: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/cdoc_pkg.sv
design/cdoc_mod25.sv
design/cdoc_walk.sv
design/calendar_date_ordinal_convert.sv
tb/calendar_date_ordinal_convert_tb.sv
